// File: rtl/core/rs485_direction_tx_queue_core_macros.svh
`ifndef RS485_DIRECTION_TX_QUEUE_CORE_MACROS_SVH
`define RS485_DIRECTION_TX_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define RDTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdtq: assertion failed");

// next-cycle implication
`define RDTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdtq: assertion failed");

`endif

// File: rtl/core/rdtq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdtq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_RECEIVE  = 2'd1,
    ST_SETTLE   = 2'd2,
    ST_TRANSMIT = 2'd3
  } line_state_t;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_READY = 2'd2;

  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_SETTLE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_RETURN = 2'd1;

  localparam logic [7:0] TICKS_RESET = 8'd2;

  // fixed part of the result word: tx_valid, tx_byte, drive, line_state
  localparam int unsigned OUT_FIXED_W = 12;

endpackage

`default_nettype wire

// File: rtl/core/rs485_direction_tx_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  contents
// in_      slave      tuser: command[1:0]; tdata: data[7:0]
// out_     master     tdata: tx_valid, tx_byte, drive_transmit, line_state,
//                            queue_count, overflow (lowest bit first)
// cfg_     write      cfg_addr 0 settle_ticks, 1 return_ticks
//
// One transaction per cycle sustained while out_tready stays high; the input register
// feeds the result register, with the queue head read ahead from its own port.
// Reset is synchronous and needs no clearing pass; unread queue entries are
// never presented. A stalled result holds and in_tready drops only when both
// the input and the result register are occupied.

module rs485_direction_tx_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire  [7:0]              in_tdata,   // data[7:0]
  input  wire  [1:0]              in_tuser,   // command[1:0]
  output logic                    out_tvalid,
  input  wire                     out_tready,
  // tx_valid[0], tx_byte[8:1], drive_transmit[9], line_state[11:10],
  // queue_count[12 +: CW], overflow[12+CW], zero pad
  output logic [((rdtq_pkg::OUT_FIXED_W + $clog2(QUEUE_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0]
                                  out_tdata,
  input  wire                     cfg_we,
  input  wire  [rdtq_pkg::CFG_AW-1:0] cfg_addr,
  input  wire  [7:0]              cfg_wdata
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW = ((rdtq_pkg::OUT_FIXED_W + CW + 1 + 7) / 8) * 8;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [7:0] queue_mem [QUEUE_DEPTH];

  logic                    in_vld_r;
  logic [1:0]              cmd_r;
  logic [7:0]              data_r;
  logic                    out_vld_r;
  logic [OW-1:0]           out_data_r;
  logic [OW-1:0]           out_data_nxt;

  logic [7:0]              settle_r;
  logic [7:0]              return_r;

  logic [AW-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic                    send_r, send_nxt;
  rdtq_pkg::line_state_t   st_r, st_nxt;
  logic [7:0]              dly_r, dly_nxt;
  logic                    drv_r, drv_nxt;

  logic [7:0]              head_mem_r;
  logic                    byp_hit_r;
  logic [7:0]              byp_data_r;
  logic [7:0]              head;

  logic                    adv;
  logic                    wr_en;
  logic                    tx_vld;
  logic [7:0]              tx_byte;
  logic                    ovf;

  assign adv        = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign head       = byp_hit_r ? byp_data_r : head_mem_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    send_nxt   = send_r;
    st_nxt     = st_r;
    dly_nxt    = dly_r;
    drv_nxt    = drv_r;
    wr_en      = 1'b0;
    tx_vld     = 1'b0;
    tx_byte    = 8'd0;
    ovf        = 1'b0;
    if (adv) begin
      case (cmd_r)
        rdtq_pkg::CMD_TICK: begin
          if (dly_r != 8'd0) dly_nxt = dly_r - 8'd1;
        end
        rdtq_pkg::CMD_PUSH: begin
          if (fill_r == FULL_CNT) begin
            ovf = 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
          end
        end
        rdtq_pkg::CMD_READY: begin
          if (send_r && fill_r != '0) begin
            tx_vld     = 1'b1;
            tx_byte    = head;
            rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
            fill_nxt   = fill_r - 1'b1;
          end
          if (fill_nxt == '0) send_nxt = 1'b0;
        end
        default: ;
      endcase

      if (!send_nxt && fill_nxt != '0 && st_r == rdtq_pkg::ST_TRANSMIT) send_nxt = 1'b1;

      unique case (st_r)
        rdtq_pkg::ST_IDLE: begin
          if (dly_nxt == 8'd0) begin
            drv_nxt = 1'b0;
            st_nxt  = rdtq_pkg::ST_RECEIVE;
          end
        end
        rdtq_pkg::ST_RECEIVE: begin
          if (fill_nxt != '0) begin
            drv_nxt = 1'b1;
            dly_nxt = settle_r;
            st_nxt  = rdtq_pkg::ST_SETTLE;
          end
        end
        rdtq_pkg::ST_SETTLE: begin
          if (dly_nxt == 8'd0) st_nxt = rdtq_pkg::ST_TRANSMIT;
        end
        rdtq_pkg::ST_TRANSMIT: begin
          if (!send_nxt) begin
            dly_nxt = return_r;
            st_nxt  = rdtq_pkg::ST_IDLE;
          end
        end
        default: ;
      endcase
    end
    out_data_nxt = OW'({ovf, fill_nxt, st_nxt, drv_nxt, tx_byte, tx_vld});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      settle_r  <= rdtq_pkg::TICKS_RESET;
      return_r  <= rdtq_pkg::TICKS_RESET;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      send_r    <= 1'b0;
      st_r      <= rdtq_pkg::ST_IDLE;
      dly_r     <= 8'd0;
      drv_r     <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          rdtq_pkg::REG_SETTLE: settle_r <= cfg_wdata;
          rdtq_pkg::REG_RETURN: return_r <= cfg_wdata;
          default: ;
        endcase
      end
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      fill_r    <= fill_nxt;
      send_r    <= send_nxt;
      st_r      <= st_nxt;
      dly_r     <= dly_nxt;
      drv_r     <= drv_nxt;
      byp_hit_r <= wr_en && (wr_ptr_r == rd_ptr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      data_r <= in_tdata;
    end
    if (adv) out_data_r <= out_data_nxt;
    byp_data_r <= data_r;
  end

  // queue storage: one write port, one registered read of the next head
  always_ff @(posedge clk) begin
    if (wr_en) queue_mem[wr_ptr_r] <= data_r;
    head_mem_r <= queue_mem[rd_ptr_nxt];
  end

endmodule

`default_nettype wire

// File: rtl/core/rdtq_port_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "rs485_direction_tx_queue_core_macros.svh"

module rdtq_port_checker #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input wire clk,
  input wire rst_n,
  input wire out_tvalid,
  input wire out_tready,
  input wire [((rdtq_pkg::OUT_FIXED_W + $clog2(QUEUE_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0]
             out_tdata
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OVF_BIT = rdtq_pkg::OUT_FIXED_W + CW;

  logic          tx_vld;
  logic [7:0]    tx_byte;
  logic          drive;
  logic [1:0]    state;
  logic [CW-1:0] count;
  logic          ovf;

  assign tx_vld  = out_tdata[0];
  assign tx_byte = out_tdata[8:1];
  assign drive   = out_tdata[9];
  assign state   = out_tdata[11:10];
  assign count   = out_tdata[rdtq_pkg::OUT_FIXED_W +: CW];
  assign ovf     = out_tdata[OVF_BIT];

  `RDTQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))

  `RDTQ_ASSERT_IMP(a_idle_byte_zero, clk, rst_n, out_tvalid && !tx_vld, tx_byte == 8'd0)

  `RDTQ_ASSERT_IMP(a_drive_match, clk, rst_n, out_tvalid && state != rdtq_pkg::ST_IDLE,
                   drive == (state != rdtq_pkg::ST_RECEIVE))

  `RDTQ_ASSERT_IMP(a_send_state, clk, rst_n, out_tvalid && tx_vld,
                   state == rdtq_pkg::ST_TRANSMIT || state == rdtq_pkg::ST_IDLE)

  `RDTQ_ASSERT_IMP(a_ovf_full, clk, rst_n, out_tvalid && ovf,
                   count == CW'(QUEUE_DEPTH) && !tx_vld)

endmodule

bind rs485_direction_tx_queue_core rdtq_port_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_rdtq_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
